>>> src/scatter_sum_sumsq_min_max_aggregator_core_macros.svh
// ----------------------------------------------------------------------------
// scatter aggregator assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef SCATTER_SUM_SUMSQ_MIN_MAX_AGGREGATOR_CORE_MACROS_SVH
`define SCATTER_SUM_SUMSQ_MIN_MAX_AGGREGATOR_CORE_MACROS_SVH

`ifndef SYNTH
`define SSA_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SSA_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SSA_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SSA_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

>>> src/ssa_pkg.sv
// ----------------------------------------------------------------------------
// ssa_pkg
// shared field widths, command codes and lane control type
// ----------------------------------------------------------------------------
package ssa_pkg;

    localparam int CMD_WIDTH   = 2;
    localparam int NODE_WIDTH  = 10;
    localparam int GROUP_WIDTH = 4;
    localparam int LANE_WIDTH  = 2;
    localparam int INPUT_LANES = 4;

    localparam logic [CMD_WIDTH-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_WIDTH-1:0] CMD_ACCUM = 2'd1;
    localparam logic [CMD_WIDTH-1:0] CMD_READ  = 2'd2;

    typedef struct packed {
        logic write;
        logic init;
    } lane_ctl_t;

endpackage

>>> src/ssa_lane.sv
// ----------------------------------------------------------------------------
// ssa_lane
// one lane: aggregate memory with registered read and the update datapath
// ----------------------------------------------------------------------------
module ssa_lane #(
    parameter int VALUE_WIDTH   = 16,
    parameter int FRACTION_BITS = 10,
    parameter int DEPTH         = 16384,
    parameter int ADDR_WIDTH    = 14
) (
    input  logic                     aclk,
    input  logic                     rd_en,
    input  logic [ADDR_WIDTH-1:0]    rd_addr,
    input  ssa_pkg::lane_ctl_t       ctl,
    input  logic [ADDR_WIDTH-1:0]    wr_addr,
    input  logic [VALUE_WIDTH-1:0]   value,
    output logic [4*VALUE_WIDTH-1:0] rd_data
);

    localparam int VW = VALUE_WIDTH;
    localparam int EW = 4 * VW;
    localparam int PW = 2 * VW + FRACTION_BITS;
    localparam logic [VW-1:0] VMAXPOS = {1'b0, {(VW-1){1'b1}}};
    localparam logic [VW-1:0] VMINNEG = {1'b1, {(VW-1){1'b0}}};
    localparam logic [EW-1:0] ENTRY_INIT = {VMINNEG, VMAXPOS, {VW{1'b0}}, {VW{1'b0}}};

    logic [EW-1:0]   mem [DEPTH];
    logic [EW-1:0]   rd_data_reg;
    logic [EW-1:0]   wr_data;
    logic [VW-1:0]   cur_sum;
    logic [VW-1:0]   cur_sq;
    logic [VW-1:0]   cur_min;
    logic [VW-1:0]   cur_max;
    logic [VW-1:0]   mag;
    logic [2*VW-1:0] sq;
    logic [PW-1:0]   sq_ext;
    logic [VW-1:0]   sq_trunc;
    logic [VW-1:0]   new_min;
    logic [VW-1:0]   new_max;

    always_ff @(posedge aclk) begin
        if (ctl.write) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign cur_sum = rd_data_reg[0 +: VW];
    assign cur_sq  = rd_data_reg[VW +: VW];
    assign cur_min = rd_data_reg[2*VW +: VW];
    assign cur_max = rd_data_reg[3*VW +: VW];

    assign mag      = value[VW-1] ? (~value + 1'b1) : value;
    assign sq       = (2*VW)'(mag) * (2*VW)'(mag);
    assign sq_ext   = PW'(sq);
    assign sq_trunc = sq_ext[FRACTION_BITS +: VW];

    assign new_min = ($signed(value) < $signed(cur_min)) ? value : cur_min;
    assign new_max = ($signed(value) > $signed(cur_max)) ? value : cur_max;

    always_comb begin
        if (ctl.init) begin
            wr_data = ENTRY_INIT;
        end else begin
            wr_data = {new_max, new_min, cur_sq + sq_trunc, cur_sum + value};
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/ssa_merge.sv
// ----------------------------------------------------------------------------
// ssa_merge
// picks the addressed lane's aggregates and holds the result beat
// ----------------------------------------------------------------------------
module ssa_merge #(
    parameter int VALUE_WIDTH = 16,
    parameter int LANES       = 4
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                load,
    input  logic                                read_ok,
    input  logic [ssa_pkg::LANE_WIDTH-1:0]      lane_sel,
    input  logic [LANES-1:0][4*VALUE_WIDTH-1:0] lane_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [VALUE_WIDTH-1:0]       m_sum,
    output logic signed [VALUE_WIDTH-1:0]       m_sum_of_squares,
    output logic signed [VALUE_WIDTH-1:0]       m_min_value,
    output logic signed [VALUE_WIDTH-1:0]       m_max_value
);

    localparam int VW = VALUE_WIDTH;
    localparam int EW = 4 * VW;

    logic [EW-1:0] sel;
    logic [EW-1:0] out_reg;
    logic          valid_reg;
    logic          valid_next;

    always_comb begin
        sel = '0;
        for (int l = 0; l < LANES; l++) begin
            if (ssa_pkg::LANE_WIDTH'(l) == lane_sel) begin
                sel = lane_data[l];
            end
        end
        if (!read_ok) begin
            sel = '0;
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            out_reg <= sel;
        end
    end

    assign m_valid          = valid_reg;
    assign m_sum            = out_reg[0 +: VW];
    assign m_sum_of_squares = out_reg[VW +: VW];
    assign m_min_value      = out_reg[2*VW +: VW];
    assign m_max_value      = out_reg[3*VW +: VW];

endmodule

>>> src/scatter_sum_sumsq_min_max_aggregator_core.sv
// ----------------------------------------------------------------------------
// scatter_sum_sumsq_min_max_aggregator_core
// each beat: lane memory read at accept, then update or result load in ST_EXEC
// (a read waits there while the output is full); no new beat is accepted until the
// read-then-write ends; a read result is valid from the cycle after the result load
// after reset a clearing pass over NODE_COUNT * group slots entries (16384 by default)
// initializes every entry; s_ready stays low until it ends
// ----------------------------------------------------------------------------
`include "scatter_sum_sumsq_min_max_aggregator_core_macros.svh"

module scatter_sum_sumsq_min_max_aggregator_core #(
    parameter int NODE_COUNT    = 1024,
    parameter int EMBED_DIMS    = 64,
    parameter int LANE_COUNT    = 4,
    parameter int VALUE_WIDTH   = 16,
    parameter int FRACTION_BITS = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ssa_pkg::CMD_WIDTH-1:0]       s_cmd,
    input  logic [ssa_pkg::NODE_WIDTH-1:0]      s_node,
    input  logic [ssa_pkg::GROUP_WIDTH-1:0]     s_dim_group,
    input  logic [ssa_pkg::LANE_WIDTH-1:0]      s_lane,
    input  logic signed [VALUE_WIDTH-1:0]       s_value_lane0,
    input  logic signed [VALUE_WIDTH-1:0]       s_value_lane1,
    input  logic signed [VALUE_WIDTH-1:0]       s_value_lane2,
    input  logic signed [VALUE_WIDTH-1:0]       s_value_lane3,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [VALUE_WIDTH-1:0]       m_sum,
    output logic signed [VALUE_WIDTH-1:0]       m_sum_of_squares,
    output logic signed [VALUE_WIDTH-1:0]       m_min_value,
    output logic signed [VALUE_WIDTH-1:0]       m_max_value
);

    localparam int VW          = VALUE_WIDTH;
    localparam int EW          = 4 * VW;
    localparam int LANES       = (LANE_COUNT < ssa_pkg::INPUT_LANES) ?
                                 LANE_COUNT : ssa_pkg::INPUT_LANES;
    localparam int GROUPS_USED = (EMBED_DIMS + LANE_COUNT - 1) / LANE_COUNT;
    localparam int GROUP_MAX   = 2 ** ssa_pkg::GROUP_WIDTH;
    localparam int GROUP_SLOTS = (GROUPS_USED < GROUP_MAX) ? GROUPS_USED : GROUP_MAX;
    localparam int DEPTH       = NODE_COUNT * GROUP_SLOTS;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [AW-1:0]                    clear_addr_reg;
    logic [AW-1:0]                    clear_addr_next;

    logic [ssa_pkg::CMD_WIDTH-1:0]    cmd_reg;
    logic [AW-1:0]                    addr_reg;
    logic                             node_ok_reg;
    logic [LANES-1:0]                 lane_ok_reg;
    logic                             read_ok_reg;
    logic [ssa_pkg::LANE_WIDTH-1:0]   lane_sel_reg;
    logic [VW-1:0]                    value_reg [LANES];

    logic                             accept;
    logic [31:0]                      in_addr_full;
    logic [AW-1:0]                    in_addr;
    logic                             in_node_ok;
    logic [LANES-1:0]                 in_lane_ok;
    logic                             in_read_ok;
    logic [VW-1:0]                    in_value [ssa_pkg::INPUT_LANES];

    logic                             out_free;
    logic                             load;
    logic                             exec_write;
    logic [AW-1:0]                    wr_addr;
    ssa_pkg::lane_ctl_t               lane_ctl [LANES];
    logic [LANES-1:0][EW-1:0]         lane_data;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    assign in_value[0] = s_value_lane0;
    assign in_value[1] = s_value_lane1;
    assign in_value[2] = s_value_lane2;
    assign in_value[3] = s_value_lane3;

    assign in_addr_full = 32'(s_node) * 32'(GROUP_SLOTS) + 32'(s_dim_group);
    assign in_addr      = in_addr_full[AW-1:0];
    assign in_node_ok   = 32'(s_node) < 32'(NODE_COUNT);
    assign in_read_ok   = in_node_ok && (32'(s_lane) < 32'(LANE_COUNT)) &&
                          (32'(s_dim_group) * 32'(LANE_COUNT) + 32'(s_lane) <
                           32'(EMBED_DIMS));

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            in_lane_ok[l] = 32'(s_dim_group) * 32'(LANE_COUNT) + 32'(l) < 32'(EMBED_DIMS);
        end
    end

    assign out_free   = !m_valid || m_ready;
    assign load       = (state_reg == ST_EXEC) && (cmd_reg == ssa_pkg::CMD_READ) && out_free;
    assign exec_write = (state_reg == ST_EXEC) && node_ok_reg &&
                        ((cmd_reg == ssa_pkg::CMD_CLEAR) || (cmd_reg == ssa_pkg::CMD_ACCUM));
    assign wr_addr    = (state_reg == ST_CLEAR) ? clear_addr_reg : addr_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (state_reg == ST_CLEAR) begin
                lane_ctl[l].write = 1'b1;
                lane_ctl[l].init  = 1'b1;
            end else begin
                lane_ctl[l].write = exec_write && lane_ok_reg[l];
                lane_ctl[l].init  = (cmd_reg == ssa_pkg::CMD_CLEAR);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == AW'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if ((cmd_reg != ssa_pkg::CMD_READ) || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
        end else begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg      <= s_cmd;
            addr_reg     <= in_addr;
            node_ok_reg  <= in_node_ok;
            lane_ok_reg  <= in_lane_ok;
            read_ok_reg  <= in_read_ok;
            lane_sel_reg <= s_lane;
            for (int l = 0; l < LANES; l++) begin
                value_reg[l] <= in_value[l];
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        ssa_lane #(
            .VALUE_WIDTH   (VALUE_WIDTH),
            .FRACTION_BITS (FRACTION_BITS),
            .DEPTH         (DEPTH),
            .ADDR_WIDTH    (AW)
        ) u_lane (
            .aclk    (aclk),
            .rd_en   (accept),
            .rd_addr (in_addr),
            .ctl     (lane_ctl[g]),
            .wr_addr (wr_addr),
            .value   (value_reg[g]),
            .rd_data (lane_data[g])
        );
    end

    ssa_merge #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .LANES       (LANES)
    ) u_merge (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .load             (load),
        .read_ok          (read_ok_reg),
        .lane_sel         (lane_sel_reg),
        .lane_data        (lane_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sum            (m_sum),
        .m_sum_of_squares (m_sum_of_squares),
        .m_min_value      (m_min_value),
        .m_max_value      (m_max_value)
    );

    `SSA_ASSERT_IMP(a_no_accept_in_clear, aclk, aresetn, state_reg == ST_CLEAR, !s_ready)
    `SSA_ASSERT_IMP(a_result_from_read, aclk, aresetn, $rose(m_valid), $past(load))
    `SSA_ASSERT_NXT(a_read_waits, aclk, aresetn, (state_reg == ST_EXEC) && (cmd_reg == ssa_pkg::CMD_READ) && m_valid && !m_ready, state_reg == ST_EXEC)

endmodule
